// ----- sv/tphl_pkg.sv -----
// ----------------------------------------------------------------------------
// tphl_pkg
// Shared constants and types for the token prefix hash ledger.
// ----------------------------------------------------------------------------
package tphl_pkg;

  localparam int LEDGER_DEPTH = 4096;
  localparam int AW = $clog2(LEDGER_DEPTH);   // store address width
  localparam int LW = AW + 1;                 // length / position width
  localparam int TW = 32;                     // token width
  localparam int HW = 64;                     // fingerprint width
  localparam int PW = HW / 2;                 // partial product operand width

  localparam logic [LW-1:0] DEPTH_LEN = LW'(LEDGER_DEPTH);

  localparam logic [HW-1:0] SEED_HASH = 64'hcbf29ce484222325;
  localparam logic [HW-1:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [HW-1:0] MIX_K1    = 64'hbf58476d1ce4e5b9;
  localparam logic [HW-1:0] MIX_K2    = 64'h94d049bb133111eb;

  localparam int SH_A = 30;
  localparam int SH_B = 27;
  localparam int SH_C = 31;

  typedef enum logic [2:0] {
    ACT_APPEND    = 3'd0,
    ACT_TRUNC     = 3'd1,
    ACT_DROP      = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_CMP_TOKEN = 3'd4,
    ACT_CMP_END   = 3'd5,
    ACT_QUERY     = 3'd6
  } action_t;

endpackage

// ----- sv/tphl_req_if.sv -----
// ----------------------------------------------------------------------------
// tphl_req_if
// Request channel: one ledger action with its token and count.
// ----------------------------------------------------------------------------
interface tphl_req_if;
  import tphl_pkg::*;

  logic          valid;
  logic          ready;
  logic [2:0]    action;
  logic [TW-1:0] token;
  logic [LW-1:0] count;

  modport source (output valid, output action, output token, output count, input ready);
  modport sink   (input valid, input action, input token, input count, output ready);
endinterface

// ----- sv/tphl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tphl_rsp_if
// Result channel: ledger status, fingerprint and compare decision.
// ----------------------------------------------------------------------------
interface tphl_rsp_if;
  import tphl_pkg::*;

  logic          valid;
  logic          ready;
  logic          status;
  logic [LW-1:0] length;
  logic [HW-1:0] fingerprint;
  logic          decision_valid;
  logic [LW-1:0] reusable;
  logic          divergent;
  logic [HW-1:0] queried_hash;

  modport source (output valid, output status, output length, output fingerprint,
                  output decision_valid, output reusable, output divergent,
                  output queried_hash, input ready);
  modport sink   (input valid, input status, input length, input fingerprint,
                  input decision_valid, input reusable, input divergent,
                  input queried_hash, output ready);
endinterface

// ----- sv/tphl_mul.sv -----
// ----------------------------------------------------------------------------
// tphl_mul
// 64x64 multiply modulo 2^64 on one 32x32 multiplier, three partial
// products in sequence. done pulses when p holds the product.
// ----------------------------------------------------------------------------
module tphl_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [tphl_pkg::HW-1:0] a,
  input  logic [tphl_pkg::HW-1:0] b,
  output logic                   done,
  output logic [tphl_pkg::HW-1:0] p
);
  import tphl_pkg::*;

  logic [HW-1:0] a_q;
  logic [HW-1:0] b_q;
  logic [1:0]    step;
  logic          run;
  logic [HW-1:0] prod;
  logic [HW-1:0] acc;
  logic [PW-1:0] mx;
  logic [PW-1:0] my;

  // lo*lo, lo*hi, hi*lo; hi*hi falls off the top
  always_comb begin
    case (step)
      2'd1: begin
        mx = a_q[PW-1:0];
        my = b_q[HW-1:PW];
      end
      2'd2: begin
        mx = a_q[HW-1:PW];
        my = b_q[PW-1:0];
      end
      default: begin
        mx = a_q[PW-1:0];
        my = b_q[PW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= run && !start && (step == 2'd3);
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        run  <= 1'b1;
        step <= 2'd0;
      end else if (run) begin
        step <= step + 2'd1;
        case (step)
          2'd0: prod <= HW'(mx) * HW'(my);
          2'd1: begin
            acc  <= prod;
            prod <= HW'(mx) * HW'(my);
          end
          2'd2: begin
            acc[HW-1:PW] <= acc[HW-1:PW] + prod[PW-1:0];
            prod         <= HW'(mx) * HW'(my);
          end
          default: begin
            acc[HW-1:PW] <= acc[HW-1:PW] + prod[PW-1:0];
            run          <= 1'b0;
          end
        endcase
      end
    end
  end

  assign p = acc;

endmodule

// ----- sv/tphl_store.sv -----
// ----------------------------------------------------------------------------
// tphl_store
// Token and fingerprint stores: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tphl_store (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [tphl_pkg::AW-1:0] waddr,
  input  logic [tphl_pkg::TW-1:0] wtok,
  input  logic [tphl_pkg::HW-1:0] whash,
  input  logic                    rd_en,
  input  logic [tphl_pkg::AW-1:0] raddr,
  output logic [tphl_pkg::TW-1:0] rtok,
  output logic [tphl_pkg::HW-1:0] rhash
);
  import tphl_pkg::*;

  logic [TW-1:0] tok_mem  [LEDGER_DEPTH];
  logic [HW-1:0] hash_mem [LEDGER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_mem[waddr]  <= wtok;
      hash_mem[waddr] <= whash;
    end
    if (rd_en) begin
      rtok  <= tok_mem[raddr];
      rhash <= hash_mem[raddr];
    end
  end

endmodule

// ----- sv/token_prefix_hash_ledger_top.sv -----
// Sequencing: a non-full append runs three multiplies on the shared 32x32
//   multiplier between the decode and result steps; truncate, drop, query
//   and compare_token that read the store pass through read and use steps;
//   other actions go from decode to the result step.
// Throughput: one request at a time; a new one is taken once the previous
//   result sits in the output register.
// Reset: synchronous; ledger empty, fingerprint at seed, compare cleared.
// ----------------------------------------------------------------------------
// token_prefix_hash_ledger_top
// Token stack with per-position running fingerprints, prefix compare and
// fingerprint query, sequenced around one shared multiplier.
// ----------------------------------------------------------------------------
module token_prefix_hash_ledger_top (
  input  logic        clk,
  input  logic        rst,
  tphl_req_if.sink    req,
  tphl_rsp_if.source  rsp
);
  import tphl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL_G, S_MUL_K1, S_MUL_K2, S_READ, S_USE, S_DONE
  } state_t;

  state_t        state;
  action_t       op;
  logic [TW-1:0] tok;
  logic [LW-1:0] cnt;
  logic [LW-1:0] len;
  logic [HW-1:0] top;
  logic [LW-1:0] cmp_pos;
  logic          cmp_mis;
  logic [AW-1:0] addr;

  logic          r_status;
  logic          r_dvalid;
  logic [LW-1:0] r_reuse;
  logic          r_diverg;
  logic [HW-1:0] r_qhash;

  logic          o_valid;
  logic          o_status;
  logic [LW-1:0] o_length;
  logic [HW-1:0] o_fp;
  logic          o_dvalid;
  logic [LW-1:0] o_reuse;
  logic          o_diverg;
  logic [HW-1:0] o_qhash;

  logic          mul_start;
  logic [HW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic          mul_done;
  logic [HW-1:0] mul_p;

  logic          st_wr;
  logic          st_rd;
  logic [TW-1:0] st_tok;
  logic [HW-1:0] st_hash;

  logic [LW-1:0] cut_n;
  logic [LW-1:0] qpos;
  logic [HW-1:0] z_g;
  logic [HW-1:0] z_g1;
  logic [HW-1:0] z_k;
  logic [HW-1:0] h_new;
  logic          full;

  // target length of truncate / drop, clamped query position
  assign cut_n = (op == ACT_DROP) ? ((cnt >= len) ? '0 : len - cnt) : cnt;
  assign qpos  = (cnt < len) ? cnt : len;
  assign full  = (len == DEPTH_LEN);

  assign z_g   = top ^ mul_p;
  assign z_g1  = z_g ^ (z_g >> SH_A);
  assign z_k   = mul_p ^ (mul_p >> SH_B);
  assign h_new = mul_p ^ (mul_p >> SH_C);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = GOLDEN;
    mul_b     = HW'(tok) + HW'(1);
    case (state)
      S_EXEC: mul_start = (op == ACT_APPEND) && !full;
      S_MUL_G: begin
        mul_start = mul_done;
        mul_a     = z_g1;
        mul_b     = MIX_K1;
      end
      S_MUL_K1: begin
        mul_start = mul_done;
        mul_a     = z_k;
        mul_b     = MIX_K2;
      end
      default: ;
    endcase
  end

  assign st_wr = (state == S_MUL_K2) && mul_done;
  assign st_rd = (state == S_READ);

  tphl_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  tphl_store u_store (
    .clk   (clk),
    .wr_en (st_wr),
    .waddr (len[AW-1:0]),
    .wtok  (tok),
    .whash (h_new),
    .rd_en (st_rd),
    .raddr (addr),
    .rtok  (st_tok),
    .rhash (st_hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= '0;
      top     <= SEED_HASH;
      cmp_pos <= '0;
      cmp_mis <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_DONE) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op       <= action_t'(req.action);
            tok      <= req.token;
            cnt      <= req.count;
            r_status <= 1'b0;
            r_dvalid <= 1'b0;
            r_reuse  <= '0;
            r_diverg <= 1'b0;
            r_qhash  <= '0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op)
            ACT_APPEND: begin
              cmp_pos <= '0;
              cmp_mis <= 1'b0;
              if (full) begin
                r_status <= 1'b1;
                state    <= S_DONE;
              end else begin
                state <= S_MUL_G;
              end
            end
            ACT_TRUNC, ACT_DROP: begin
              cmp_pos <= '0;
              cmp_mis <= 1'b0;
              if (cut_n >= len) begin
                state <= S_DONE;
              end else begin
                len <= cut_n;
                if (cut_n == '0) begin
                  top   <= SEED_HASH;
                  state <= S_DONE;
                end else begin
                  addr  <= AW'(cut_n - LW'(1));
                  state <= S_READ;
                end
              end
            end
            ACT_CLEAR: begin
              cmp_pos <= '0;
              cmp_mis <= 1'b0;
              len     <= '0;
              top     <= SEED_HASH;
              state   <= S_DONE;
            end
            ACT_CMP_TOKEN: begin
              if (cmp_mis) begin
                state <= S_DONE;
              end else if (cmp_pos < len) begin
                addr  <= cmp_pos[AW-1:0];
                state <= S_READ;
              end else begin
                // candidate runs past the ledger end
                cmp_mis <= 1'b1;
                state   <= S_DONE;
              end
            end
            ACT_CMP_END: begin
              r_dvalid <= 1'b1;
              r_reuse  <= cmp_pos;
              r_diverg <= (cmp_pos < len);
              cmp_pos  <= '0;
              cmp_mis  <= 1'b0;
              state    <= S_DONE;
            end
            ACT_QUERY: begin
              if (qpos == '0) begin
                r_qhash <= SEED_HASH;
                state   <= S_DONE;
              end else begin
                addr  <= AW'(qpos - LW'(1));
                state <= S_READ;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_MUL_G: begin
          if (mul_done) begin
            state <= S_MUL_K1;
          end
        end
        S_MUL_K1: begin
          if (mul_done) begin
            state <= S_MUL_K2;
          end
        end
        S_MUL_K2: begin
          if (mul_done) begin
            top   <= h_new;
            len   <= len + LW'(1);
            state <= S_DONE;
          end
        end
        S_READ: state <= S_USE;
        S_USE: begin
          case (op)
            ACT_TRUNC, ACT_DROP: top <= st_hash;
            ACT_QUERY:           r_qhash <= st_hash;
            ACT_CMP_TOKEN: begin
              if (st_tok == tok) begin
                cmp_pos <= cmp_pos + LW'(1);
              end else begin
                cmp_mis <= 1'b1;
              end
            end
            default: ;
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_status <= r_status;
            o_length <= len;
            o_fp     <= top;
            o_dvalid <= r_dvalid;
            o_reuse  <= r_reuse;
            o_diverg <= r_diverg;
            o_qhash  <= r_qhash;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = o_valid;
  assign rsp.status         = o_status;
  assign rsp.length         = o_length;
  assign rsp.fingerprint    = o_fp;
  assign rsp.decision_valid = o_dvalid;
  assign rsp.reusable       = o_reuse;
  assign rsp.divergent      = o_diverg;
  assign rsp.queried_hash   = o_qhash;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= DEPTH_LEN)
    else $error("ledger length above depth");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL_G || state == S_MUL_K1 || state == S_MUL_K2))
    else $error("multiplier finished outside a multiply step");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    st_wr |-> (len < DEPTH_LEN))
    else $error("store write with ledger full");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion step");
`endif

endmodule

// ----- dv/tb_token_prefix_hash_ledger_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_token_prefix_hash_ledger_top
// Self-checking bench for the token prefix hash ledger. A directed table covers
// the empty ledger, clamping, every action and the compare corner cases, and a
// fill run covers the full ledger. Random request streams follow, with compare
// runs, mostly well-formed, against the live ledger, under several sender-gap
// and receiver-stall profiles plus one long receiver hold-off. Every request is
// predicted in-bench and each reply is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_token_prefix_hash_ledger_top;
  import tphl_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic          status;
    logic [LW-1:0] length;
    logic [HW-1:0] fingerprint;
    logic          decision_valid;
    logic [LW-1:0] reusable;
    logic          divergent;
    logic [HW-1:0] queried_hash;
  } ledger_rsp_t;

  typedef struct packed {
    logic [2:0]    act;
    logic [TW-1:0] tok;
    logic [LW-1:0] cnt;
    logic          typed;
    ledger_rsp_t   want;
  } step_row_t;

  logic clk;
  logic rst;

  tphl_req_if req ();
  tphl_rsp_if rsp ();

  token_prefix_hash_ledger_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ledger shadow
  logic [TW-1:0] ledger_tokens [LEDGER_DEPTH];
  logic [HW-1:0] ledger_hashes [LEDGER_DEPTH];
  logic [LW-1:0] ledger_len;
  logic [HW-1:0] ledger_fp;
  logic [LW-1:0] cand_pos;
  logic          cand_mismatch;

  ledger_rsp_t   awaited_replies [$];
  step_row_t     directed_steps [$];

  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int            hold_left;
  int unsigned   sent_requests;
  int unsigned   errors;

  function automatic logic [HW-1:0] splitmix_final(logic [HW-1:0] z);
    z = z ^ (z >> SH_A);
    z = z * MIX_K1;
    z = z ^ (z >> SH_B);
    z = z * MIX_K2;
    return z ^ (z >> SH_C);
  endfunction

  // fingerprint after the first n tokens
  function automatic logic [HW-1:0] prefix_hash(logic [LW-1:0] n);
    if (n == '0) return SEED_HASH;
    return ledger_hashes[AW'(n - 1'b1)];
  endfunction

  function automatic void cut_ledger(logic [LW-1:0] n);
    if (n < ledger_len) begin
      ledger_len = n;
      ledger_fp  = prefix_hash(n);
    end
  endfunction

  function automatic ledger_rsp_t ledger_step(logic [2:0] act, logic [TW-1:0] tok,
                                              logic [LW-1:0] cnt);
    ledger_rsp_t r;
    logic [HW-1:0] h;
    r = '0;
    case (act)
      ACT_APPEND: begin
        cand_pos = '0;
        cand_mismatch = 1'b0;
        if (ledger_len >= DEPTH_LEN) begin
          r.status = 1'b1;
        end else begin
          h = splitmix_final(ledger_fp ^ (GOLDEN * ({32'd0, tok} + 64'd1)));
          ledger_tokens[AW'(ledger_len)] = tok;
          ledger_hashes[AW'(ledger_len)] = h;
          ledger_fp = h;
          ledger_len = ledger_len + 1'b1;
        end
      end
      ACT_TRUNC: begin
        cand_pos = '0;
        cand_mismatch = 1'b0;
        cut_ledger(cnt);
      end
      ACT_DROP: begin
        cand_pos = '0;
        cand_mismatch = 1'b0;
        cut_ledger((cnt >= ledger_len) ? '0 : ledger_len - cnt);
      end
      ACT_CLEAR: begin
        cand_pos = '0;
        cand_mismatch = 1'b0;
        ledger_len = '0;
        ledger_fp = SEED_HASH;
      end
      ACT_CMP_TOKEN: begin
        // once a mismatch is seen the candidate is frozen until compare_end or a ledger edit
        if (!cand_mismatch) begin
          if (cand_pos < ledger_len && ledger_tokens[AW'(cand_pos)] == tok)
            cand_pos = cand_pos + 1'b1;
          else
            cand_mismatch = 1'b1;
        end
      end
      ACT_CMP_END: begin
        r.decision_valid = 1'b1;
        r.reusable = cand_pos;
        r.divergent = (cand_pos < ledger_len);
        cand_pos = '0;
        cand_mismatch = 1'b0;
      end
      ACT_QUERY: begin
        r.queried_hash = prefix_hash((cnt < ledger_len) ? cnt : ledger_len);
      end
      default: ;
    endcase
    r.length = ledger_len;
    r.fingerprint = ledger_fp;
    return r;
  endfunction

  function automatic step_row_t row(logic [2:0] a, logic [TW-1:0] t, logic [LW-1:0] c);
    step_row_t s;
    s = '0;
    s.act = a;
    s.tok = t;
    s.cnt = c;
    return s;
  endfunction

  // row whose reply is known outright: ledger empty afterwards
  function automatic step_row_t at_empty(logic [2:0] a, logic [TW-1:0] t, logic [LW-1:0] c,
                                         logic dv, logic [HW-1:0] qh);
    step_row_t s;
    s = row(a, t, c);
    s.typed = 1'b1;
    s.want.fingerprint = SEED_HASH;
    s.want.decision_valid = dv;
    s.want.queried_hash = qh;
    return s;
  endfunction

  function automatic void add_step(step_row_t s);
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  task automatic issue_request(logic [2:0] act, logic [TW-1:0] tok, logic [LW-1:0] cnt,
                               logic use_fixed = 1'b0, ledger_rsp_t fixed = '0);
    ledger_rsp_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.token  <= tok;
    req.count  <= cnt;
    do @(posedge clk); while (!req.ready);
    r = ledger_step(act, tok, cnt);
    awaited_replies.insert(awaited_replies.size(), use_fixed ? fixed : r);
    if (act != ACT_UNUSED) sent_requests++;
  endtask

  function automatic logic [LW-1:0] pick_count();
    if ($urandom_range(1) == 0) return LW'($urandom_range(0, ledger_len));
    return LW'($urandom);
  endfunction

  task automatic random_scenario();
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    logic [TW-1:0] t;
    pick = $urandom_range(99);
    if (pick < 28) begin
      if (ledger_len > 48) begin
        issue_request(ACT_TRUNC, $urandom, LW'($urandom_range(0, 16)));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) issue_request(ACT_APPEND, $urandom, LW'($urandom));
      end
    end else if (pick < 62) begin
      // candidate run: mostly the ledger's own tokens, sometimes off or too long
      n = ($urandom_range(2) == 0) ? ledger_len : $urandom_range(0, ledger_len + 2);
      for (i = 0; i < n; i++) begin
        if (i < ledger_len && $urandom_range(19) != 0) t = ledger_tokens[AW'(i)];
        else t = $urandom;
        issue_request(ACT_CMP_TOKEN, t, LW'($urandom));
        case ($urandom_range(39))
          0: issue_request(ACT_QUERY, $urandom, pick_count());
          1: issue_request(ACT_APPEND, $urandom, LW'($urandom));
          default: ;
        endcase
      end
      if ($urandom_range(9) != 0) issue_request(ACT_CMP_END, $urandom, LW'($urandom));
    end else if (pick < 70) begin
      issue_request(ACT_TRUNC, $urandom, pick_count());
    end else if (pick < 78) begin
      issue_request(ACT_DROP, $urandom, LW'($urandom_range(0, 6)));
    end else if (pick < 80) begin
      issue_request(ACT_DROP, $urandom, pick_count());
    end else if (pick < 88) begin
      issue_request(ACT_QUERY, $urandom, pick_count());
    end else if (pick < 91) begin
      issue_request(ACT_CLEAR, $urandom, LW'($urandom));
    end else begin
      issue_request(3'($urandom), $urandom, LW'($urandom));
    end
  endtask

  // reply side: random stalls, or a counted hold-off when one is pending
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic check_field(string name, logic [HW-1:0] want, logic [HW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ledger_rsp_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with no request outstanding: expected none, actual len %0d",
                 $time, rsp.length);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", HW'(want.status), HW'(rsp.status));
        check_field("length", HW'(want.length), HW'(rsp.length));
        check_field("fingerprint", want.fingerprint, rsp.fingerprint);
        check_field("decision_valid", HW'(want.decision_valid), HW'(rsp.decision_valid));
        check_field("reusable", HW'(want.reusable), HW'(rsp.reusable));
        check_field("divergent", HW'(want.divergent), HW'(rsp.divergent));
        check_field("queried_hash", want.queried_hash, rsp.queried_hash);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** token_prefix_hash_ledger_top: FAILED **");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned target;
    step_row_t s;

    rst = 1'b1;
    req.valid = 1'b0;
    req.action = ACT_APPEND;
    req.token = '0;
    req.count = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    sent_requests = 0;
    errors = 0;
    ledger_len = '0;
    ledger_fp = SEED_HASH;
    cand_pos = '0;
    cand_mismatch = 1'b0;

    add_step(at_empty(ACT_QUERY, 32'h0, 13'd0, 1'b0, SEED_HASH));
    add_step(at_empty(ACT_CMP_END, 32'h0, 13'd0, 1'b1, '0));
    add_step(at_empty(ACT_DROP, 32'h0, 13'h1fff, 1'b0, '0));
    add_step(at_empty(ACT_UNUSED, 32'hffff_ffff, 13'h1fff, 1'b0, '0));
    add_step(row(ACT_APPEND, 32'h0000_0000, 13'd0));
    add_step(row(ACT_APPEND, 32'hffff_ffff, 13'h1fff));
    add_step(row(ACT_APPEND, 32'ha5a5_a5a5, 13'd0));
    add_step(row(ACT_QUERY, 32'h0, 13'h1fff));
    add_step(row(ACT_QUERY, 32'h0, 13'd0));
    add_step(row(ACT_CMP_TOKEN, 32'h0000_0000, 13'd0));
    add_step(row(ACT_QUERY, 32'h0, 13'd1));
    add_step(row(ACT_CMP_TOKEN, 32'hffff_ffff, 13'd0));
    add_step(row(ACT_CMP_TOKEN, 32'ha5a5_a5a5, 13'd0));
    add_step(row(ACT_CMP_TOKEN, 32'h5a5a_5a5a, 13'd0));   // past the end
    add_step(row(ACT_CMP_END, 32'h0, 13'd0));
    add_step(row(ACT_CMP_TOKEN, 32'h0000_0000, 13'd0));
    add_step(row(ACT_CMP_TOKEN, 32'h0000_0001, 13'd0));
    add_step(row(ACT_CMP_END, 32'h0, 13'd0));
    add_step(row(ACT_CMP_TOKEN, 32'h0000_0000, 13'd0));
    add_step(row(ACT_APPEND, 32'h5a5a_5a5a, 13'd0));      // restarts compare
    add_step(row(ACT_CMP_END, 32'h0, 13'd0));
    add_step(row(ACT_TRUNC, 32'h0, 13'd4096));
    add_step(row(ACT_TRUNC, 32'h0, 13'd2));
    add_step(row(ACT_DROP, 32'h0, 13'd1));
    add_step(at_empty(ACT_DROP, 32'h0, 13'd4096, 1'b0, '0));
    add_step(row(ACT_APPEND, 32'h1234_5678, 13'd0));
    add_step(at_empty(ACT_CLEAR, 32'h0, 13'd0, 1'b0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      issue_request(s.act, s.tok, s.cnt, s.typed, s.want);
    end

    // fill to capacity, then hit the full-ledger refusal and clamps at 4096
    repeat (LEDGER_DEPTH) issue_request(ACT_APPEND, $urandom, LW'($urandom));
    issue_request(ACT_APPEND, $urandom, LW'($urandom));
    issue_request(ACT_QUERY, $urandom, 13'd4096);
    issue_request(ACT_QUERY, $urandom, 13'h1fff);
    issue_request(ACT_CMP_TOKEN, ledger_tokens[0], 13'd0);
    issue_request(ACT_CMP_TOKEN, ledger_tokens[1], 13'd0);
    issue_request(ACT_CMP_END, $urandom, 13'd0);
    issue_request(ACT_DROP, $urandom, 13'd4095);
    issue_request(ACT_QUERY, $urandom, 13'd1);
    issue_request(ACT_CLEAR, $urandom, 13'd0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      if (phase == 0) begin
        // long reply hold-off while requests keep coming
        @(posedge clk);
        hold_left = 300;
      end
      target = sent_requests + 125;
      while (sent_requests < target) random_scenario();
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("** token_prefix_hash_ledger_top: PASSED **");
    end else begin
      $display("** token_prefix_hash_ledger_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tphl_pkg.sv
sv/tphl_req_if.sv
sv/tphl_rsp_if.sv
sv/tphl_mul.sv
sv/tphl_store.sv
sv/token_prefix_hash_ledger_top.sv
dv/tb_token_prefix_hash_ledger_top.sv
